@@ rtl/core/sce_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and micro-op program of the spline evaluator.
package sce_pkg;

  localparam int WEIGHT_BITS = 30;
  localparam int RF_DEPTH    = 20;
  localparam int UOP_LAST    = 45;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, 63'b0};

  // floor(m / 6) = (m * RECIP6) >> RECIP6_SHIFT for any magnitude up to 2^64
  localparam logic signed [63:0] RECIP6       = 64'shAAAA_AAAA_AAAA_AAAB;
  localparam int                 RECIP6_SHIFT = 66;

  typedef logic [5:0] pc_t;

  typedef enum logic [2:0] {
    OP_LDK,   // load knot field
    OP_LDQ,   // load query abscissa
    OP_LDONE, // load 1.0 in weight format
    OP_ADD,   // saturating add
    OP_SUB,   // saturating subtract
    OP_MUL,   // product, truncated and saturated
    OP_DIVS,  // (a << shift) / b
    OP_DIV6   // a / 6, reciprocal multiply
  } op_t;

  typedef enum logic [4:0] {
    R_X, R_XLO, R_XHI, R_H, R_DH, R_DL, R_WA, R_WB, R_YLO, R_YHI,
    R_CLO, R_CHI, R_ONE, R_AA, R_BB, R_T1, R_T2, R_VAL, R_SLP, R_CRV
  } rf_t;

  // SH_D6: unsigned reciprocal operand, shift by RECIP6_SHIFT
  typedef enum logic [1:0] {SH_W, SH_F, SH_D6} shift_t;

  typedef enum logic [1:0] {KM_ABS, KM_ORD, KM_CRV} kmem_t;

  typedef enum logic [1:0] {KA_MID, KA_LO, KA_HI} kaddr_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_S_RD, ST_S_CMP, ST_EX_RD, ST_EX_OP, ST_EX_WAIT, ST_FIN
  } state_t;

  typedef struct packed {
    op_t    op;
    rf_t    ra;
    rf_t    rb;
    rf_t    rd;
    shift_t sh;
    kmem_t  km;
    kaddr_t ka;
    logic   chk;  // finish as bad when the written value is zero
  } uop_t;

  typedef struct packed {
    logic   knot_wr;
    logic   q_capture;
    logic   srch_step;
    kaddr_t ka;
    uop_t   u;
    logic   alu_wr;
    logic   unit_start;
    logic   unit_wr;
    logic   publish;
    logic   bad;
  } cmd_t;

  typedef struct packed {
    logic n_small;
    logic srch_done;
    logic res_zero;
    logic unit_done;
  } sts_t;

  function automatic uop_t uop_alu(op_t op, rf_t ra, rf_t rb, rf_t rd);
    uop_t u;
    u.op  = op;
    u.ra  = ra;
    u.rb  = rb;
    u.rd  = rd;
    u.sh  = SH_W;
    u.km  = KM_ABS;
    u.ka  = KA_LO;
    u.chk = 1'b0;
    return u;
  endfunction

  function automatic uop_t uop_ldk(kmem_t km, kaddr_t ka, rf_t rd);
    uop_t u;
    u    = uop_alu(OP_LDK, R_X, R_X, rd);
    u.km = km;
    u.ka = ka;
    return u;
  endfunction

  function automatic uop_t uop_unit(op_t op, rf_t ra, rf_t rb, rf_t rd, shift_t sh);
    uop_t u;
    u    = uop_alu(op, ra, rb, rd);
    u.sh = sh;
    return u;
  endfunction

  function automatic uop_t uop_hchk(rf_t ra, rf_t rb, rf_t rd);
    uop_t u;
    u     = uop_alu(OP_SUB, ra, rb, rd);
    u.chk = 1'b1;
    return u;
  endfunction

  // Evaluation program; runs once the interval is known.
  function automatic uop_t uop_rom(pc_t pc);
    uop_t u;
    case (pc)
      6'd0:  u = uop_ldk(KM_ABS, KA_LO, R_XLO);
      6'd1:  u = uop_ldk(KM_ABS, KA_HI, R_XHI);
      6'd2:  u = uop_hchk(R_XHI, R_XLO, R_H);
      6'd3:  u = uop_alu(OP_LDQ, R_X, R_X, R_X);
      6'd4:  u = uop_alu(OP_SUB, R_XHI, R_X, R_DH);
      6'd5:  u = uop_alu(OP_SUB, R_X, R_XLO, R_DL);
      6'd6:  u = uop_unit(OP_DIVS, R_DH, R_H, R_WA, SH_W);
      6'd7:  u = uop_unit(OP_DIVS, R_DL, R_H, R_WB, SH_W);
      6'd8:  u = uop_ldk(KM_ORD, KA_LO, R_YLO);
      6'd9:  u = uop_ldk(KM_ORD, KA_HI, R_YHI);
      6'd10: u = uop_ldk(KM_CRV, KA_LO, R_CLO);
      6'd11: u = uop_ldk(KM_CRV, KA_HI, R_CHI);
      6'd12: u = uop_alu(OP_LDONE, R_X, R_X, R_ONE);
      6'd13: u = uop_unit(OP_MUL, R_WA, R_WA, R_AA, SH_W);
      6'd14: u = uop_unit(OP_MUL, R_WB, R_WB, R_BB, SH_W);
      // value
      6'd15: u = uop_unit(OP_MUL, R_WA, R_YLO, R_T1, SH_W);
      6'd16: u = uop_unit(OP_MUL, R_WB, R_YHI, R_T2, SH_W);
      6'd17: u = uop_alu(OP_ADD, R_T1, R_T2, R_VAL);
      6'd18: u = uop_unit(OP_MUL, R_AA, R_WA, R_T1, SH_W);
      6'd19: u = uop_alu(OP_SUB, R_T1, R_WA, R_T1);
      6'd20: u = uop_unit(OP_MUL, R_T1, R_CLO, R_T1, SH_W);
      6'd21: u = uop_unit(OP_MUL, R_BB, R_WB, R_T2, SH_W);
      6'd22: u = uop_alu(OP_SUB, R_T2, R_WB, R_T2);
      6'd23: u = uop_unit(OP_MUL, R_T2, R_CHI, R_T2, SH_W);
      6'd24: u = uop_alu(OP_ADD, R_T1, R_T2, R_T1);
      6'd25: u = uop_unit(OP_MUL, R_H, R_H, R_T2, SH_F);
      6'd26: u = uop_unit(OP_MUL, R_T1, R_T2, R_T1, SH_F);
      6'd27: u = uop_unit(OP_DIV6, R_T1, R_T1, R_T1, SH_D6);
      6'd28: u = uop_alu(OP_ADD, R_VAL, R_T1, R_VAL);
      // slope
      6'd29: u = uop_alu(OP_SUB, R_YHI, R_YLO, R_T1);
      6'd30: u = uop_unit(OP_DIVS, R_T1, R_H, R_SLP, SH_F);
      6'd31: u = uop_alu(OP_ADD, R_AA, R_AA, R_T1);
      6'd32: u = uop_alu(OP_ADD, R_T1, R_AA, R_T1);
      6'd33: u = uop_alu(OP_SUB, R_ONE, R_T1, R_T1);
      6'd34: u = uop_alu(OP_ADD, R_BB, R_BB, R_T2);
      6'd35: u = uop_alu(OP_ADD, R_T2, R_BB, R_T2);
      6'd36: u = uop_alu(OP_SUB, R_T2, R_ONE, R_T2);
      6'd37: u = uop_unit(OP_MUL, R_T1, R_CLO, R_T1, SH_W);
      6'd38: u = uop_unit(OP_MUL, R_T2, R_CHI, R_T2, SH_W);
      6'd39: u = uop_alu(OP_ADD, R_T1, R_T2, R_T1);
      6'd40: u = uop_unit(OP_MUL, R_T1, R_H, R_T1, SH_F);
      6'd41: u = uop_unit(OP_DIV6, R_T1, R_T1, R_T1, SH_D6);
      6'd42: u = uop_alu(OP_ADD, R_SLP, R_T1, R_SLP);
      // curvature
      6'd43: u = uop_unit(OP_MUL, R_WA, R_CLO, R_T1, SH_W);
      6'd44: u = uop_unit(OP_MUL, R_WB, R_CHI, R_T2, SH_W);
      6'd45: u = uop_alu(OP_ADD, R_T1, R_T2, R_CRV);
      default: u = uop_alu(OP_ADD, R_T1, R_T2, R_T1);
    endcase
    return u;
  endfunction

endpackage

@@ rtl/core/spline_curve_evaluate_unit.sv @@
`timescale 1ns / 1ps
// Top level of the cubic spline evaluator: controller plus datapath.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  kind, knot_index, x_value, y_value, curvature_value
// out      output     out_valid/out_stall  value, slope, curvature, bad_interval, interval_low
// cfg      input      cfg_we               cfg_data (knot_count)
//
// A knot write completes in the cycle its transaction is accepted; no result.
// A query's time is set mostly by the one-bit-per-cycle divider (three divisions
// by the interval width); the partial-product multiplier (17 products, two of
// them the reciprocal multiply for the divides by six) sets most of the rest.
// Fewer than two knots, or a zero-width interval, ends the query early.
// in_stall is high while a query runs; the finished result sits in an output
// register, so the next transaction is taken while out_stall holds it.
// rst is synchronous and clears control state and knot_count; knot memories
// are not cleared.
module spline_curve_evaluate_unit #(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [5:0]          knot_index,
  input  logic signed [31:0]  x_value,
  input  logic signed [31:0]  y_value,
  input  logic signed [31:0]  curvature_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  value,
  output logic signed [31:0]  slope,
  output logic signed [31:0]  curvature,
  output logic                bad_interval,
  output logic [5:0]          interval_low,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_data
);

  sce_pkg::cmd_t cmd;
  sce_pkg::sts_t sts;

  // sequencing: accept, binary search, evaluation program, publish
  sce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // knot tables, search registers, register file, multiplier and divider
  sce_dp #(
    .MAX_KNOTS (MAX_KNOTS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .knot_index      (knot_index),
    .x_value         (x_value),
    .y_value         (y_value),
    .curvature_value (curvature_value),
    .value           (value),
    .slope           (slope),
    .curvature       (curvature),
    .bad_interval    (bad_interval),
    .interval_low    (interval_low)
  );

endmodule

@@ rtl/core/sce_mul.sv @@
`timescale 1ns / 1ps
// Sequential 64x64 signed multiplier with truncating shift and saturation.
module sce_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  input  sce_pkg::shift_t     sh,
  output logic                done,
  output logic signed [63:0]  result
);

  logic [63:0]  ma, mb;
  logic         neg;
  sce_pkg::shift_t sh_q;
  logic [127:0] acc;
  logic [1:0]   step;
  logic         busy, fin;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [1:0]   pos;
  logic [127:0] acc_next, shifted;
  logic         ovf;
  logic [63:0]  mag;
  logic signed [63:0] res_next;

  // one 32x32 partial product per cycle
  assign pa       = step[1] ? ma[63:32] : ma[31:0];
  assign pb       = step[0] ? mb[63:32] : mb[31:0];
  assign pp       = pa * pb;
  assign pos      = 2'({1'b0, step[1]} + {1'b0, step[0]});
  assign acc_next = acc + ({64'b0, pp} << {pos, 5'b0});

  always_comb begin
    case (sh_q)
      sce_pkg::SH_W: shifted = acc >> sce_pkg::WEIGHT_BITS;
      sce_pkg::SH_F: shifted = acc >> FRAC_BITS;
      default:       shifted = acc >> sce_pkg::RECIP6_SHIFT;
    endcase
  end

  assign ovf      = |shifted[127:63];
  assign mag      = shifted[63:0];

  always_comb begin
    if (neg) begin
      res_next = ovf ? sce_pkg::S64_MIN : -$signed(mag);
    end else begin
      res_next = ovf ? sce_pkg::S64_MAX : $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // reciprocal operand of a divide by six is an unsigned magnitude
  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= a[63] ? 64'(-a) : 64'(a);
      mb   <= (sh == sce_pkg::SH_D6) ? 64'(b) : (b[63] ? 64'(-b) : 64'(b));
      neg  <= a[63] ^ (b[63] & (sh != sce_pkg::SH_D6));
      sh_q <= sh;
      acc  <= '0;
    end else if (busy) begin
      acc <= acc_next;
    end
    if (fin) begin
      result <= res_next;
    end
  end

endmodule

@@ rtl/core/sce_div.sv @@
`timescale 1ns / 1ps
// Restoring 64-bit signed divider, one quotient bit per cycle, truncating.
module sce_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [63:0]  dividend,
  input  logic signed [63:0]  divisor,
  output logic                done,
  output logic signed [63:0]  result
);

  logic [63:0] dvd, dsr, rem;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy, fin;

  logic [64:0] rem_sh;
  logic [65:0] diff;
  logic        ge;

  assign rem_sh = {rem, dvd[63]};
  assign diff   = {1'b0, rem_sh} - {2'b0, dsr};
  assign ge     = ~diff[65];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // dvd shifts out dividend bits and collects quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend[63] ? 64'(-dividend) : 64'(dividend);
      dsr <= divisor[63] ? 64'(-divisor) : 64'(divisor);
      neg <= dividend[63] ^ divisor[63];
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[63:0] : rem_sh[63:0];
      dvd <= {dvd[62:0], ge};
    end
    if (fin) begin
      result <= neg ? -$signed(dvd) : $signed(dvd);
    end
  end

endmodule

@@ rtl/core/sce_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: accept, interval search sequencing and evaluation program.
module sce_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            kind,
  output logic            out_valid,
  input  logic            out_stall,
  input  sce_pkg::sts_t   sts,
  output sce_pkg::cmd_t   cmd
);

  sce_pkg::state_t state, state_next;
  sce_pkg::pc_t    pc, pc_next;
  logic            bad, bad_next;
  logic            out_valid_next;
  logic            out_free;
  logic            is_unit;
  sce_pkg::uop_t   u;

  assign u        = sce_pkg::uop_rom(pc);
  assign out_free = ~out_valid | ~out_stall;
  assign is_unit  = (u.op == sce_pkg::OP_MUL) || (u.op == sce_pkg::OP_DIVS) ||
                    (u.op == sce_pkg::OP_DIV6);

  always_comb begin
    state_next = state;
    pc_next    = pc;
    bad_next   = bad;
    case (state)
      sce_pkg::ST_IDLE: begin
        if (in_valid && kind) begin
          pc_next    = '0;
          bad_next   = sts.n_small;
          state_next = sts.n_small ? sce_pkg::ST_FIN : sce_pkg::ST_S_RD;
        end
      end
      sce_pkg::ST_S_RD: begin
        state_next = sts.srch_done ? sce_pkg::ST_EX_RD : sce_pkg::ST_S_CMP;
      end
      sce_pkg::ST_S_CMP: state_next = sce_pkg::ST_S_RD;
      sce_pkg::ST_EX_RD: state_next = sce_pkg::ST_EX_OP;
      sce_pkg::ST_EX_OP: begin
        if (is_unit) begin
          state_next = sce_pkg::ST_EX_WAIT;
        end else if (u.chk && sts.res_zero) begin
          bad_next   = 1'b1;
          state_next = sce_pkg::ST_FIN;
        end else if (pc == sce_pkg::pc_t'(sce_pkg::UOP_LAST)) begin
          state_next = sce_pkg::ST_FIN;
        end else begin
          pc_next    = pc + 6'd1;
          state_next = sce_pkg::ST_EX_RD;
        end
      end
      sce_pkg::ST_EX_WAIT: begin
        if (sts.unit_done) begin
          if (pc == sce_pkg::pc_t'(sce_pkg::UOP_LAST)) begin
            state_next = sce_pkg::ST_FIN;
          end else begin
            pc_next    = pc + 6'd1;
            state_next = sce_pkg::ST_EX_RD;
          end
        end
      end
      sce_pkg::ST_FIN: begin
        if (out_free) state_next = sce_pkg::ST_IDLE;
      end
      default: state_next = sce_pkg::ST_IDLE;
    endcase

    if (state == sce_pkg::ST_FIN && out_free) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_comb begin
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.u          = u;
    cmd.ka         = sce_pkg::KA_MID;
    case (state)
      sce_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.knot_wr   = in_valid & ~kind;
        cmd.q_capture = in_valid & kind;
      end
      sce_pkg::ST_S_RD:    cmd.ka = sce_pkg::KA_MID;
      sce_pkg::ST_S_CMP:   cmd.srch_step = 1'b1;
      sce_pkg::ST_EX_RD:   cmd.ka = u.ka;
      sce_pkg::ST_EX_OP: begin
        cmd.alu_wr     = ~is_unit;
        cmd.unit_start = is_unit;
      end
      sce_pkg::ST_EX_WAIT: cmd.unit_wr = sts.unit_done;
      sce_pkg::ST_FIN: begin
        cmd.publish = out_free;
        cmd.bad     = bad;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sce_pkg::ST_IDLE;
      pc        <= '0;
      bad       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      bad       <= bad_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/core/sce_dp.sv @@
`timescale 1ns / 1ps
// Datapath: knot memories, search registers, register file, ALU and units.
module sce_dp #(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  sce_pkg::cmd_t       cmd,
  output sce_pkg::sts_t       sts,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_data,
  input  logic [5:0]          knot_index,
  input  logic signed [31:0]  x_value,
  input  logic signed [31:0]  y_value,
  input  logic signed [31:0]  curvature_value,
  output logic signed [31:0]  value,
  output logic signed [31:0]  slope,
  output logic signed [31:0]  curvature,
  output logic                bad_interval,
  output logic [5:0]          interval_low
);

  localparam int KW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int CW = (KW + 1 > 7) ? KW + 1 : 7;

  function automatic logic signed [63:0] sat_add(logic signed [63:0] p,
                                                  logic signed [63:0] q);
    logic [64:0] s;
    s = {p[63], p} + {q[63], q};
    if (s[64] != s[63]) return s[64] ? sce_pkg::S64_MIN : sce_pkg::S64_MAX;
    return $signed(s[63:0]);
  endfunction

  function automatic logic signed [63:0] sat_sub(logic signed [63:0] p,
                                                  logic signed [63:0] q);
    logic [64:0] s;
    s = {p[63], p} - {q[63], q};
    if (s[64] != s[63]) return s[64] ? sce_pkg::S64_MIN : sce_pkg::S64_MAX;
    return $signed(s[63:0]);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // configuration
  logic [6:0] knot_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= 7'd0;
    end else if (cfg_we) begin
      knot_count <= cfg_data;
    end
  end

  // knot memories
  logic signed [31:0] kabs_mem [MAX_KNOTS];
  logic signed [31:0] kord_mem [MAX_KNOTS];
  logic signed [31:0] kcrv_mem [MAX_KNOTS];
  logic signed [31:0] kabs_rd, kord_rd, kcrv_rd;
  logic [CW-1:0]      widx;
  logic               wr_ok;
  logic [KW-1:0]      kaddr;

  assign widx  = CW'(knot_index);
  assign wr_ok = widx < CW'(MAX_KNOTS);

  always_ff @(posedge clk) begin
    if (cmd.knot_wr && wr_ok) begin
      kabs_mem[widx[KW-1:0]] <= x_value;
      kord_mem[widx[KW-1:0]] <= y_value;
      kcrv_mem[widx[KW-1:0]] <= curvature_value;
    end
    kabs_rd <= kabs_mem[kaddr];
    kord_rd <= kord_mem[kaddr];
    kcrv_rd <= kcrv_mem[kaddr];
  end

  // interval search
  logic [KW-1:0]      lo, hi, mid, hi_init;
  logic [CW-1:0]      cnt_ext, n_eff;
  logic [KW:0]        span;
  logic signed [31:0] xq;

  assign cnt_ext = CW'(knot_count);
  assign n_eff   = (cnt_ext > CW'(MAX_KNOTS)) ? CW'(MAX_KNOTS) : cnt_ext;
  assign hi_init = KW'(n_eff - CW'(1));
  assign mid     = KW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign span    = {1'b0, hi} - {1'b0, lo};

  always_comb begin
    case (cmd.ka)
      sce_pkg::KA_LO: kaddr = lo;
      sce_pkg::KA_HI: kaddr = hi;
      default:        kaddr = mid;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.q_capture) begin
      xq <= x_value;
      lo <= '0;
      hi <= hi_init;
    end else if (cmd.srch_step) begin
      if (kabs_rd > xq) hi <= mid;
      else              lo <= mid;
    end
  end

  // register file, two registered read ports
  logic signed [63:0] rf [sce_pkg::RF_DEPTH];
  logic signed [63:0] a_d, b_d;
  logic signed [63:0] alu_res, wdata, unit_res;
  logic signed [63:0] val_r, slp_r, crv_r;
  logic               rf_we;

  assign rf_we = cmd.alu_wr | cmd.unit_wr;
  assign wdata = cmd.unit_wr ? unit_res : alu_res;

  always_ff @(posedge clk) begin
    if (rf_we) rf[cmd.u.rd] <= wdata;
    a_d <= rf[cmd.u.ra];
    b_d <= rf[cmd.u.rb];
  end

  always_comb begin
    case (cmd.u.op)
      sce_pkg::OP_LDK: begin
        case (cmd.u.km)
          sce_pkg::KM_ORD: alu_res = 64'(kord_rd);
          sce_pkg::KM_CRV: alu_res = 64'(kcrv_rd);
          default:         alu_res = 64'(kabs_rd);
        endcase
      end
      sce_pkg::OP_LDQ:   alu_res = 64'(xq);
      sce_pkg::OP_LDONE: alu_res = 64'sd1 <<< sce_pkg::WEIGHT_BITS;
      sce_pkg::OP_ADD:   alu_res = sat_add(a_d, b_d);
      sce_pkg::OP_SUB:   alu_res = sat_sub(a_d, b_d);
      default:           alu_res = a_d;
    endcase
  end

  // shared multiply and divide units; divide by six runs on the multiplier
  logic               mul_start, div_start, mul_done, div_done;
  logic signed [63:0] mul_res, div_res, dvd_in, dsr_in, mul_b;

  assign mul_start = cmd.unit_start &&
                     ((cmd.u.op == sce_pkg::OP_MUL) || (cmd.u.op == sce_pkg::OP_DIV6));
  assign div_start = cmd.unit_start && (cmd.u.op == sce_pkg::OP_DIVS);
  assign mul_b     = (cmd.u.op == sce_pkg::OP_DIV6) ? sce_pkg::RECIP6 : b_d;

  assign dvd_in = (cmd.u.sh == sce_pkg::SH_W) ? (a_d <<< sce_pkg::WEIGHT_BITS)
                                              : (a_d <<< FRAC_BITS);
  assign dsr_in = b_d;

  sce_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (a_d),
    .b      (mul_b),
    .sh     (cmd.u.sh),
    .done   (mul_done),
    .result (mul_res)
  );

  sce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_in),
    .divisor  (dsr_in),
    .done     (div_done),
    .result   (div_res)
  );

  assign unit_res = mul_done ? mul_res : div_res;

  // result holders and output register
  always_ff @(posedge clk) begin
    if (rf_we && cmd.u.rd == sce_pkg::R_VAL) val_r <= wdata;
    if (rf_we && cmd.u.rd == sce_pkg::R_SLP) slp_r <= wdata;
    if (rf_we && cmd.u.rd == sce_pkg::R_CRV) crv_r <= wdata;
    if (cmd.publish) begin
      value        <= cmd.bad ? 32'sd0 : sat32(val_r);
      slope        <= cmd.bad ? 32'sd0 : sat32(slp_r);
      curvature    <= cmd.bad ? 32'sd0 : sat32(crv_r);
      bad_interval <= cmd.bad;
      interval_low <= 6'(lo);
    end
  end

  assign sts.n_small   = n_eff < CW'(2);
  assign sts.srch_done = span <= (KW+1)'(1);
  assign sts.res_zero  = alu_res == 64'sd0;
  assign sts.unit_done = mul_done | div_done;

endmodule

@@ test/tb_spline_curve_evaluate_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the spline evaluator: knot tables, queries, random handshakes.
module tb_spline_curve_evaluate_unit;

  // kind codes of an input transaction
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // table shapes used by the generator
  localparam int TBL_SMOOTH = 0;  // sorted, moderate spacing
  localparam int TBL_DUPS   = 1;  // sorted, some zero-width intervals
  localparam int TBL_WILD   = 2;  // unordered, full-range values
  localparam int TBL_WIDE   = 3;  // sorted, wide spacing and large values

  localparam int  N_SLOTS     = 64;
  localparam int  DRAIN_WAIT  = 500;      // a bit over one worst-case query
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic               kind;
    logic [5:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] c;
  } knot_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] slope;
    logic signed [31:0] curvature;
    logic               bad;
    logic [5:0]         low;
  } spline_point_t;

  logic clk, rst;
  logic in_valid, in_stall, kind, out_valid, out_stall, bad_interval, cfg_we;
  logic [5:0] knot_index, interval_low;
  logic signed [31:0] x_value, y_value, curvature_value, value, slope, curvature;
  logic [6:0] cfg_data;

  spline_curve_evaluate_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .knot_index(knot_index), .x_value(x_value),
    .y_value(y_value), .curvature_value(curvature_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .slope(slope), .curvature(curvature),
    .bad_interval(bad_interval), .interval_low(interval_low),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Predictor state: mirrors the knot memories and knot_count.
  logic signed [31:0] mir_x [N_SLOTS];
  logic signed [31:0] mir_y [N_SLOTS];
  logic signed [31:0] mir_c [N_SLOTS];
  logic [6:0]         mir_count;

  // Generator's own copy of the table it last wrote, for picking query points.
  logic signed [31:0] gen_x [N_SLOTS];

  knot_req_t     pending_reqs[$];
  spline_point_t expected_points[$];

  int     errors;
  int     acc_cnt, iss_cnt;   // accepted vs presented input transactions
  int     in_gap, out_hold;
  bit     quiet;              // phase with no idling at all
  longint cycles;

  // ---------------- fixed-point helpers ----------------
  function automatic logic signed [63:0] clamp64(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF_FFFF_FFFF) return sce_pkg::S64_MAX;
    if (v < -128'sh8000_0000_0000_0000) return sce_pkg::S64_MIN;
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [127:0] w;
    w = a;
    w = w + b;
    return clamp64(w);
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [127:0] w;
    w = a;
    w = w - b;
    return clamp64(w);
  endfunction

  // exact product, truncated toward zero by sh bits, saturated to 64 bits
  function automatic logic signed [63:0] mulq(input logic signed [63:0] p,
                                              input logic signed [63:0] q, input int sh);
    logic signed [127:0] pp, qq, dv;
    pp = p;
    qq = q;
    dv = 1;
    dv = dv << sh;
    pp = (pp * qq) / dv;
    return clamp64(pp);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Spline evaluation at abscissa xq over the mirrored table.
  function automatic spline_point_t spline_eval(input logic signed [31:0] xq);
    spline_point_t r;
    int n, lo, hi, mid;
    logic signed [63:0] x, h, dh, dl, wa, wb, ylo, yhi, clo, chi, one;
    logic signed [63:0] aa, bb, lin, t, hh, cub, s1, ca, cb, u;
    r = '0;
    r.bad = 1'b1;
    n = mir_count;
    if (n > N_SLOTS) n = N_SLOTS;
    if (n < 2) return r;
    x = xq;
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (hi + lo) / 2;
      if (64'(mir_x[mid]) > x) hi = mid;
      else lo = mid;
    end
    r.low = lo[5:0];
    h = 64'(mir_x[hi]) - 64'(mir_x[lo]);
    if (h == 0) return r;
    r.bad = 1'b0;
    one = 64'sd1 << sce_pkg::WEIGHT_BITS;
    dh = 64'(mir_x[hi]) - x;
    dl = x - 64'(mir_x[lo]);
    wa = (dh * one) / h;
    wb = (dl * one) / h;
    ylo = mir_y[lo];
    yhi = mir_y[hi];
    clo = mir_c[lo];
    chi = mir_c[hi];
    aa = mulq(wa, wa, sce_pkg::WEIGHT_BITS);
    bb = mulq(wb, wb, sce_pkg::WEIGHT_BITS);
    lin = sadd(mulq(wa, ylo, sce_pkg::WEIGHT_BITS), mulq(wb, yhi, sce_pkg::WEIGHT_BITS));
    t = sadd(mulq(ssub(mulq(aa, wa, sce_pkg::WEIGHT_BITS), wa), clo, sce_pkg::WEIGHT_BITS),
             mulq(ssub(mulq(bb, wb, sce_pkg::WEIGHT_BITS), wb), chi, sce_pkg::WEIGHT_BITS));
    hh = mulq(h, h, 16);
    cub = mulq(t, hh, 16) / 6;
    r.value = sat32(sadd(lin, cub));
    s1 = ((yhi - ylo) * (64'sd1 << 16)) / h;
    ca = ssub(one, sadd(sadd(aa, aa), aa));
    cb = ssub(sadd(sadd(bb, bb), bb), one);
    u = sadd(mulq(ca, clo, sce_pkg::WEIGHT_BITS), mulq(cb, chi, sce_pkg::WEIGHT_BITS));
    r.slope = sat32(sadd(s1, mulq(u, h, 16) / 6));
    r.curvature = sat32(sadd(mulq(wa, clo, sce_pkg::WEIGHT_BITS),
                             mulq(wb, chi, sce_pkg::WEIGHT_BITS)));
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // ---------------- clock, reset, cycle limit ----------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------- input acceptance + prediction ----------------
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      acc_cnt <= acc_cnt + 1;
      if (kind == KIND_WRITE) begin
        mir_x[knot_index] <= x_value;
        mir_y[knot_index] <= y_value;
        mir_c[knot_index] <= curvature_value;
      end else begin
        expected_points.push_back(spline_eval(x_value));
      end
    end
  end

  // ---------------- driver: presents one pending transaction at a time ----------------
  always @(negedge clk) begin
    knot_req_t req;
    if (!rst && (!in_valid || acc_cnt == iss_cnt)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req = pending_reqs.pop_front();
        kind <= req.kind;
        knot_index <= req.idx;
        x_value <= req.x;
        y_value <= req.y;
        curvature_value <= req.c;
        in_valid <= 1'b1;
        iss_cnt <= iss_cnt + 1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- output backpressure ----------------
  always @(negedge clk) begin
    if (!rst) begin
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_stall <= 1'b1;
      end else if (quiet || $urandom_range(0, 99) < 60) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        out_hold <= pick_gap();
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    spline_point_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{value, slope, curvature, bad_interval, interval_low};
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result val=%h slp=%h crv=%h bad=%b low=%0d",
                 $time, value, slope, curvature, bad_interval, interval_low);
        errors <= errors + 1;
      end else begin
        want = expected_points.pop_front();
        if (got !== want) begin
          $display("%0t: exp val=%h slp=%h crv=%h bad=%b low=%0d", $time,
                   want.value, want.slope, want.curvature, want.bad, want.low);
          $display("%0t: got val=%h slp=%h crv=%h bad=%b low=%0d", $time,
                   got.value, got.slope, got.curvature, got.bad, got.low);
          errors <= errors + 1;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_points.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // only written while the block is idle
  task automatic set_count(input logic [6:0] n);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = n;
    mir_count = n;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_data = 7'($urandom);
  endtask

  task automatic load_table(input int shape);
    int order [N_SLOTS];
    int j, k, tmp;
    longint pos, step;
    knot_req_t req;
    pos = (shape == TBL_WIDE) ? -(longint'(1) << 29) : -longint'($urandom_range(0, 1 << 22));
    for (j = 0; j < N_SLOTS; j++) begin
      order[j] = j;
      case (shape)
        TBL_WILD: gen_x[j] = $urandom;
        TBL_WIDE: step = $urandom_range(1 << 16, 1 << 24);
        TBL_DUPS: step = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 1 << 20);
        default:  step = $urandom_range(1 << 12, 1 << 20);
      endcase
      if (shape != TBL_WILD) begin
        gen_x[j] = pos[31:0];
        pos = pos + step;
      end
    end
    // write slots in shuffled order
    for (j = N_SLOTS - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    for (j = 0; j < N_SLOTS; j++) begin
      req.kind = KIND_WRITE;
      req.idx = 6'(order[j]);
      req.x = gen_x[order[j]];
      if (shape == TBL_WILD || shape == TBL_WIDE) begin
        req.y = $urandom;
        req.c = $urandom;
      end else begin
        req.y = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
        req.c = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      end
      pending_reqs.push_back(req);
    end
  endtask

  task automatic add_query(input logic signed [31:0] xq);
    knot_req_t req;
    req.kind = KIND_QUERY;
    req.idx = 6'($urandom);
    req.x = xq;
    req.y = $urandom;
    req.c = $urandom;
    pending_reqs.push_back(req);
  endtask

  // query points: inside an interval mostly, then ends, knots, anything
  task automatic add_queries(input int n, input int used);
    int j, i, r;
    longint w, xq;
    if (used < 2) used = 2;
    if (used > N_SLOTS) used = N_SLOTS;
    for (j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      i = $urandom_range(0, used - 2);
      w = longint'(gen_x[i + 1]) - longint'(gen_x[i]);
      if (r < 65 && w > 0) xq = longint'(gen_x[i]) + ($urandom % w);
      else if (r < 75) xq = longint'(gen_x[0]) - $urandom_range(0, 1 << 20);
      else if (r < 85) xq = longint'(gen_x[used - 1]) + $urandom_range(0, 1 << 20);
      else if (r < 92) xq = gen_x[i];
      else xq = $signed($urandom);
      if (xq > 64'sh7FFF_FFFF) xq = 64'sh7FFF_FFFF;
      if (xq < -64'sh8000_0000) xq = -64'sh8000_0000;
      add_query(xq[31:0]);
    end
  endtask

  initial begin
    int p, shape, n;
    logic [6:0] counts [5];
    errors = 0; acc_cnt = 0; iss_cnt = 0; in_gap = 0; out_hold = 0;
    cycles = 0; quiet = 1'b0; mir_count = '0;
    rst = 1'b1; in_valid = 1'b0; out_stall = 1'b0; cfg_we = 1'b0; cfg_data = '0;
    kind = KIND_WRITE; knot_index = '0; x_value = '0; y_value = '0; curvature_value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: whole table written, then the count extremes
    load_table(TBL_SMOOTH);
    wait_idle();
    counts = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127};
    for (p = 0; p < 5; p++) begin
      set_count(counts[p]);
      add_query(32'sh8000_0000);
      add_query(32'sh7FFF_FFFF);
      add_query(gen_x[1]);
      add_queries(1, counts[p]);
      wait_idle();
    end

    // zero-width interval: duplicates table, query exactly at knots
    load_table(TBL_DUPS);
    wait_idle();
    set_count(7'd64);
    for (p = 0; p < 3; p++) add_query(gen_x[$urandom_range(0, 63)]);
    wait_idle();

    // random phases
    for (p = 0; p < 13; p++) begin
      quiet = ($urandom_range(0, 3) == 0);
      shape = $urandom_range(TBL_SMOOTH, TBL_WIDE);
      load_table(shape);
      wait_idle();
      case ($urandom_range(0, 5))
        0: n = 2;
        1: n = 3;
        2: n = 64;
        3: n = $urandom_range(65, 127);
        default: n = $urandom_range(2, 64);
      endcase
      set_count(n[6:0]);
      add_queries(36, n);
      wait_idle();
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
